// ----- hw/rtl/phcd_pkg.sv -----
// Shared types and constants of the Prewitt/Harris corner detector.
`default_nettype none
package phcd_pkg;

    // Width used for position and size comparisons (holds sizes up to 4096 plus margins).
    localparam int XW = 14;

    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int CSUM_W = 24;
    localparam int WSUM_W = 26;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_BORDER_MARGIN    = 3'd2,
        REG_HARRIS_K         = 3'd3,
        REG_CORNER_THRESHOLD = 3'd4
    } cfg_reg_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_GRAD = 9'b000000100,
        S_ACC  = 9'b000001000,
        S_WIN  = 9'b000010000,
        S_MUL1 = 9'b000100000,
        S_MUL2 = 9'b001000000,
        S_RESP = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    // One column of the gradient window: sums of gx*gx, gx*gy and gy*gy.
    typedef struct packed {
        logic signed [CSUM_W-1:0] xx;
        logic signed [CSUM_W-1:0] xy;
        logic signed [CSUM_W-1:0] yy;
    } gcol_t;

endpackage
`default_nettype wire

// ----- hw/rtl/phcd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module phcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/prewitt_harris_corner_detector_top.sv -----
// Top level of the streaming Harris corner detector on 3x3 Prewitt gradients.
// Flow: a pixel is taken only while the control is idle, so no new pixel is taken before
// the last one is through. Each pixel passes the line memory access and, past column 0,
// the gradient, the serial column sums and the window update; inside the reporting band
// the multiply chain and the output stage follow, and a corner that waits at the output
// holds the flow. A corner comes from the window that the last accepted pixel completes.
// Reset: rst_n sets the control state, counters, windows, output flag and settings to defaults;
// the line memories and data registers are not cleared and hold undefined data until written.
`default_nettype none
module prewitt_harris_corner_detector_top
    import phcd_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int RESPONSE_BITS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [46:0] cfg_data,
    // Pixel input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  wire logic        s_axis_tuser,   // [0] frame_start
    // Corner output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [9:0] corner_col, [21:10] corner_row, [RESPONSE_BITS+21:22] response, zero padding above
    output logic [((22+RESPONSE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int ODW = ((22 + RESPONSE_BITS + 7) / 8) * 8;
    localparam int PAD = ODW - 22 - RESPONSE_BITS;

    // Config registers. Writes land at once; the user, not the block, keeps them to idle.
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [5:0]  margin_reg;
    logic [15:0] k_reg;
    logic [46:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 12'd480;
            margin_reg <= 6'd10;
            k_reg      <= 16'd13107;
            thresh_reg <= 47'd10000000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:      width_reg  <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:     height_reg <= cfg_data[11:0];
                REG_BORDER_MARGIN:    margin_reg <= cfg_data[5:0];
                REG_HARRIS_K:         k_reg      <= cfg_data[15:0];
                REG_CORNER_THRESHOLD: thresh_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Effective sizes: width clamped to [3, MAX_WIDTH], height and margin given a floor.
    logic [XW-1:0] w_eff;
    logic [XW-1:0] h_eff;
    logic [XW-1:0] m_eff;

    always_comb
    begin
        w_eff = XW'(width_reg);
        if (w_eff < XW'(3))
        begin
            w_eff = XW'(3);
        end
        if (w_eff > XW'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        h_eff = XW'(height_reg);
        if (h_eff < XW'(3))
        begin
            h_eff = XW'(3);
        end
        m_eff = XW'(margin_reg);
        if (m_eff < XW'(2))
        begin
            m_eff = XW'(2);
        end
    end

    state_t state_reg, state_next;

    logic [CW-1:0]    column_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [CW-1:0]    c_reg;
    logic [ROW_W-1:0] r_reg;
    logic [PIX_W-1:0] p_reg;

    logic in_accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Position of the incoming pixel and the position that follows it.
    logic [CW-1:0]    c_in;
    logic [ROW_W-1:0] r_in;
    logic [CW-1:0]    c_nx;
    logic [ROW_W-1:0] r_nx;

    always_comb
    begin
        c_in = s_axis_tuser ? '0 : column_count_reg;
        r_in = s_axis_tuser ? '0 : row_count_reg;
        if (XW'(c_in) >= XW'(MAX_WIDTH))
        begin
            c_in = '0;
        end
        if (XW'(c_in) + XW'(1) >= w_eff)
        begin
            c_nx = '0;
            r_nx = (XW'(r_in) + XW'(1) >= h_eff) ? '0 : r_in + ROW_W'(1);
        end
        else
        begin
            c_nx = c_in + CW'(1);
            r_nx = r_in;
        end
    end

    // Pixel line memory: [7:0] previous row, [15:8] the row before it.
    logic          pix_we;
    logic [15:0]   pix_rdata;
    // Gradient line memory: [21:0] previous row, [43:22] the row before it; gx above gy.
    logic          grad_we;
    logic [43:0]   grad_rdata;
    logic [21:0]   grad_new;

    phcd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (c_reg),
        .wdata ({pix_rdata[7:0], p_reg}),
        .re    (in_accept),
        .raddr (c_in),
        .rdata (pix_rdata)
    );

    phcd_ram #(.WIDTH(44), .DEPTH(MAX_WIDTH)) u_grad_ram (
        .clk   (clk),
        .we    (grad_we),
        .waddr (c_reg - CW'(1)),
        .wdata ({grad_rdata[21:0], grad_new}),
        .re    (in_accept),
        .raddr (c_in - CW'(1)),
        .rdata (grad_rdata)
    );

    assign pix_we  = (state_reg == S_READ);
    assign grad_we = (state_reg == S_GRAD);

    // 3x3 pixel window, row 0 oldest line, column 2 newest pixel.
    logic [PIX_W-1:0] pwin_reg [3][3];

    // Prewitt gradients of the window center; zero on the image border.
    logic [9:0]               top_sum, bot_sum, lft_sum, rgt_sum;
    logic signed [GRAD_W-1:0] gx, gy;

    always_comb
    begin
        top_sum = 10'(pwin_reg[0][0]) + 10'(pwin_reg[0][1]) + 10'(pwin_reg[0][2]);
        bot_sum = 10'(pwin_reg[2][0]) + 10'(pwin_reg[2][1]) + 10'(pwin_reg[2][2]);
        lft_sum = 10'(pwin_reg[0][0]) + 10'(pwin_reg[1][0]) + 10'(pwin_reg[2][0]);
        rgt_sum = 10'(pwin_reg[0][2]) + 10'(pwin_reg[1][2]) + 10'(pwin_reg[2][2]);
        if (XW'(c_reg) >= XW'(2) && XW'(r_reg) >= XW'(2))
        begin
            gx = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
            gy = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum});
        end
        else
        begin
            gx = '0;
            gy = '0;
        end
    end

    assign grad_new = {gx, gy};

    // Gradients of one column (new row and the two stored rows), summed serially.
    logic signed [GRAD_W-1:0] ax_reg [3];
    logic signed [GRAD_W-1:0] ay_reg [3];
    logic [1:0]               idx_reg;
    logic signed [CSUM_W-1:0] sxx_reg, sxy_reg, syy_reg;
    logic signed [21:0]       pxx, pxy, pyy;

    assign pxx = ax_reg[idx_reg] * ax_reg[idx_reg];
    assign pxy = ax_reg[idx_reg] * ay_reg[idx_reg];
    assign pyy = ay_reg[idx_reg] * ay_reg[idx_reg];

    gcol_t gcol_reg [3];

    logic signed [WSUM_W-1:0] a_reg, b_reg, d_reg;
    logic signed [WSUM_W-1:0] a_sum, b_sum, d_sum;

    assign a_sum = WSUM_W'(gcol_reg[1].xx) + WSUM_W'(gcol_reg[2].xx) + WSUM_W'(sxx_reg);
    assign b_sum = WSUM_W'(gcol_reg[1].xy) + WSUM_W'(gcol_reg[2].xy) + WSUM_W'(sxy_reg);
    assign d_sum = WSUM_W'(gcol_reg[1].yy) + WSUM_W'(gcol_reg[2].yy) + WSUM_W'(syy_reg);

    // Only pixels at least margin away from every edge are reported.
    logic in_band;
    assign in_band = (XW'(c_reg) >= m_eff + XW'(2)) &&
                     (XW'(c_reg) + m_eff < w_eff + XW'(2)) &&
                     (XW'(r_reg) >= m_eff + XW'(2)) &&
                     (XW'(r_reg) + m_eff < h_eff + XW'(2));

    // Response chain: det = A*D - B*B, kt = floor(k * (A+D)^2 / 65536).
    logic signed [WSUM_W:0]     tr;
    logic signed [2*WSUM_W-1:0] ad_reg, bb_reg;
    logic [63:0]                tr2_reg;
    logic signed [63:0]         det_reg;
    logic [79:0]                ktp;
    logic [47:0]                kt_reg;
    logic signed [63:0]         resp_reg;
    logic [63:0]                mag;

    assign tr  = (WSUM_W+1)'(a_reg) + (WSUM_W+1)'(d_reg);
    assign ktp = tr2_reg * k_reg;
    assign mag = resp_reg[63] ? 64'(-resp_reg) : 64'(resp_reg);

    // Output register.
    logic                     out_valid_reg;
    logic [COL_W-1:0]         ocol_reg;
    logic [ROW_W-1:0]         orow_reg;
    logic [RESPONSE_BITS-1:0] oresp_reg;
    logic                     hit;
    logic                     out_free;

    assign hit      = (mag > 64'(thresh_reg));
    assign out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    generate
        if (PAD > 0)
        begin : g_pad
            assign m_axis_tdata = {{PAD{1'b0}}, oresp_reg, orow_reg, ocol_reg};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {oresp_reg, orow_reg, ocol_reg};
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_accept) state_next = S_READ;
            S_READ: state_next = (c_reg == '0) ? S_IDLE : S_GRAD;
            S_GRAD: state_next = S_ACC;
            S_ACC:  if (idx_reg == 2'd2) state_next = S_WIN;
            S_WIN:  state_next = in_band ? S_MUL1 : S_IDLE;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_RESP;
            S_RESP: state_next = S_OUT;
            S_OUT:  if (!hit || out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pwin_reg[i][j] <= '0;
                end
                gcol_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                column_count_reg <= c_nx;
                row_count_reg    <= r_nx;
            end
            if (state_reg == S_READ)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pwin_reg[i][0] <= pwin_reg[i][1];
                    pwin_reg[i][1] <= pwin_reg[i][2];
                end
                pwin_reg[0][2] <= pix_rdata[15:8];
                pwin_reg[1][2] <= pix_rdata[7:0];
                pwin_reg[2][2] <= p_reg;
            end
            if (state_reg == S_GRAD)
            begin
                idx_reg <= '0;
            end
            if (state_reg == S_ACC)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (state_reg == S_WIN)
            begin
                gcol_reg[0] <= gcol_reg[1];
                gcol_reg[1] <= gcol_reg[2];
                gcol_reg[2] <= '{xx: sxx_reg, xy: sxy_reg, yy: syy_reg};
            end
            if (state_reg == S_OUT && hit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            c_reg <= c_in;
            r_reg <= r_in;
            p_reg <= s_axis_tdata;
        end
        if (state_reg == S_GRAD)
        begin
            ax_reg[0] <= gx;
            ay_reg[0] <= gy;
            ax_reg[1] <= grad_rdata[21:11];
            ay_reg[1] <= grad_rdata[10:0];
            ax_reg[2] <= grad_rdata[43:33];
            ay_reg[2] <= grad_rdata[32:22];
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            syy_reg   <= '0;
        end
        if (state_reg == S_ACC)
        begin
            sxx_reg <= sxx_reg + CSUM_W'(pxx);
            sxy_reg <= sxy_reg + CSUM_W'(pxy);
            syy_reg <= syy_reg + CSUM_W'(pyy);
        end
        if (state_reg == S_WIN)
        begin
            a_reg <= a_sum;
            b_reg <= b_sum;
            d_reg <= d_sum;
        end
        if (state_reg == S_MUL1)
        begin
            ad_reg  <= a_reg * d_reg;
            bb_reg  <= b_reg * b_reg;
            tr2_reg <= 64'(tr * tr);
        end
        if (state_reg == S_MUL2)
        begin
            det_reg <= 64'(ad_reg) - 64'(bb_reg);
            kt_reg  <= ktp[63:16];
        end
        if (state_reg == S_RESP)
        begin
            resp_reg <= det_reg - $signed({16'd0, kt_reg});
        end
        if (state_reg == S_OUT && hit && out_free)
        begin
            ocol_reg  <= COL_W'(c_reg - CW'(2));
            orow_reg  <= r_reg - ROW_W'(2);
            oresp_reg <= resp_reg[RESPONSE_BITS-1:0];
        end
    end

    // A pixel transfer always starts the line memory access in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_READ))
        else $error("pixel transfer did not start a line memory access");

    // The position counter never leaves the line memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        XW'(column_count_reg) < XW'(MAX_WIDTH))
        else $error("column counter beyond line memory depth");

    // A corner is only loaded from a window that passed the border check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL1) |-> $past(state_reg == S_WIN && in_band))
        else $error("response computed outside the reporting band");

    // A pending corner is never overwritten by the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg && $stable(oresp_reg))
        else $error("pending corner lost");

endmodule
`default_nettype wire

// ----- tb/sv/tb_prewitt_harris_corner_detector_top.sv -----
// Self-checking testbench of the streaming Prewitt/Harris corner detector.
`default_nettype none
module tb_prewitt_harris_corner_detector_top
    import phcd_pkg::*;
();

    localparam int MAX_W     = 1024;
    localparam int RESP_BITS = 48;
    localparam int OUT_W     = ((22 + RESP_BITS + 7) / 8) * 8;

    // Pattern kinds used when a frame of pixels is built.
    localparam int PAT_NOISE   = 0;
    localparam int PAT_CHECKER = 1;
    localparam int PAT_BLOCKS  = 2;
    localparam int PAT_BROKEN  = 3;
    localparam int PAT_ANY     = -1;

    typedef struct {
        logic [7:0] pixel;
        logic       frame_start;
    } pixel_item_t;

    typedef struct {
        logic [9:0]  col;
        logic [11:0] row;
        logic [47:0] response;
    } corner_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index;
    logic [46:0]          cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] pixel
    logic                 s_axis_tuser;   // [0] frame_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [9:0] corner_col, [21:10] corner_row, [69:22] response, zero padding above
    logic [OUT_W-1:0]     m_axis_tdata;

    prewitt_harris_corner_detector_top #(
        .MAX_WIDTH     (MAX_W),
        .RESPONSE_BITS (RESP_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Pixels waiting to be sent and corners waiting to be seen.
    pixel_item_t pixel_q[$];
    corner_t     corner_q[$];
    int          mismatch_count;

    // Random idling is switched off over one long stretch of cycles.
    int          cycle_count = 0;
    logic        no_idle;

    // A toggle of hold_req asks the receiver for one long hold-off.
    logic        hold_req;
    logic        hold_ack;
    int          hold_left;

    // Register copies held by the corner predictor.
    int                   width_reg;
    int                   height_reg;
    int                   margin_reg;
    int                   k_reg;
    longint unsigned      thresh_reg;

    // Line memories and windows of the corner predictor.
    logic [7:0]           pix_row1 [MAX_W];
    logic [7:0]           pix_row2 [MAX_W];
    logic signed [10:0]   gx_row1  [MAX_W];
    logic signed [10:0]   gy_row1  [MAX_W];
    logic signed [10:0]   gx_row2  [MAX_W];
    logic signed [10:0]   gy_row2  [MAX_W];
    int                   pix_win  [3][3];
    longint               grad_win [3][3];
    int                   col_pos;
    int                   row_pos;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
    begin
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    end
    endtask

    // Works out the corner, if any, that one accepted pixel produces.
    function automatic void predict_corner(input logic [7:0] p, input logic fs);
        int              w;
        int              h;
        int              m;
        int              c;
        int              r;
        int              g;
        int              gx;
        int              gy;
        int              ax[3];
        int              ay[3];
        longint          a;
        longint          b;
        longint          d;
        longint          resp;
        longint unsigned tr;
        longint unsigned kt;
        longint unsigned mag;
        corner_t         hit;
        begin
            w = width_reg;
            h = height_reg;
            m = margin_reg;
            if (w < 3) w = 3;
            if (w > MAX_W) w = MAX_W;
            if (h < 3) h = 3;
            if (m < 2) m = 2;

            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= MAX_W) col_pos = 0;
            c = col_pos;
            r = row_pos;

            for (int i = 0; i < 3; i++)
            begin
                pix_win[i][0] = pix_win[i][1];
                pix_win[i][1] = pix_win[i][2];
            end
            pix_win[0][2] = int'(pix_row2[c]);
            pix_win[1][2] = int'(pix_row1[c]);
            pix_win[2][2] = int'(p);
            pix_row2[c]   = pix_row1[c];
            pix_row1[c]   = p;

            if (c >= 1)
            begin
                g  = c - 1;
                gx = 0;
                gy = 0;
                if (g >= 1 && r >= 2)
                begin
                    gx = (pix_win[2][0] + pix_win[2][1] + pix_win[2][2])
                       - (pix_win[0][0] + pix_win[0][1] + pix_win[0][2]);
                    gy = (pix_win[0][2] + pix_win[1][2] + pix_win[2][2])
                       - (pix_win[0][0] + pix_win[1][0] + pix_win[2][0]);
                end
                ax[0] = gx;
                ay[0] = gy;
                ax[1] = int'(gx_row1[g]);
                ay[1] = int'(gy_row1[g]);
                ax[2] = int'(gx_row2[g]);
                ay[2] = int'(gy_row2[g]);
                gx_row2[g] = gx_row1[g];
                gy_row2[g] = gy_row1[g];
                gx_row1[g] = 11'(gx);
                gy_row1[g] = 11'(gy);

                for (int j = 0; j < 2; j++)
                    for (int i = 0; i < 3; i++)
                        grad_win[j][i] = grad_win[j + 1][i];
                grad_win[2][0] = 0;
                grad_win[2][1] = 0;
                grad_win[2][2] = 0;
                for (int i = 0; i < 3; i++)
                begin
                    grad_win[2][0] += longint'(ax[i]) * ax[i];
                    grad_win[2][1] += longint'(ax[i]) * ay[i];
                    grad_win[2][2] += longint'(ay[i]) * ay[i];
                end

                // Only pixels at least the margin away from every edge are reported.
                if (c >= m + 2 && c + m < w + 2 && r >= m + 2 && r + m < h + 2)
                begin
                    a    = grad_win[0][0] + grad_win[1][0] + grad_win[2][0];
                    b    = grad_win[0][1] + grad_win[1][1] + grad_win[2][1];
                    d    = grad_win[0][2] + grad_win[1][2] + grad_win[2][2];
                    tr   = longint'(a + d);
                    kt   = ((tr * tr) * longint'(k_reg)) >> 16;
                    resp = (a * d - b * b) - longint'(kt);
                    mag  = (resp < 0) ? longint'(-resp) : longint'(resp);
                    if (mag > thresh_reg)
                    begin
                        hit.col      = 10'(c - 2);
                        hit.row      = 12'(r - 2);
                        hit.response = resp[47:0];
                        corner_q.insert(corner_q.size(), hit);
                    end
                end
            end

            if (c + 1 >= w)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
            end
        end
    endfunction

    // The long stretch without random idling.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        no_idle     <= (cycle_count >= 1500 && cycle_count < 4500);
    end

    // Pixel driver. It also tracks register and pixel transfers for the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:      width_reg  = int'(cfg_data[10:0]);
                    REG_IMAGE_HEIGHT:     height_reg = int'(cfg_data[11:0]);
                    REG_BORDER_MARGIN:    margin_reg = int'(cfg_data[5:0]);
                    REG_HARRIS_K:         k_reg      = int'(cfg_data[15:0]);
                    REG_CORNER_THRESHOLD: thresh_reg = 64'(cfg_data);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_corner(s_axis_tdata, s_axis_tuser);

            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pixel_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 16))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q[0].pixel;
                    s_axis_tuser  <= pixel_q[0].frame_start;
                    void'(pixel_q.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Corner receiver: random stalls, one long hold-off on request, and the field check.
    always @(posedge clk or negedge rst_n)
    begin
        corner_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_ack      <= 1'b0;
        end
        else
        begin
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req != hold_ack)
            begin
                hold_ack      <= hold_req;
                hold_left     <= 3000;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 16);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (corner_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected corner transfer, data %h",
                                              m_axis_tdata));
                end
                else
                begin
                    want = corner_q.pop_front();
                    if (m_axis_tdata[9:0] !== want.col)
                        report_mismatch($sformatf("corner_col %0d, expected %0d",
                                                  m_axis_tdata[9:0], want.col));
                    if (m_axis_tdata[21:10] !== want.row)
                        report_mismatch($sformatf("corner_row %0d, expected %0d",
                                                  m_axis_tdata[21:10], want.row));
                    if (m_axis_tdata[69:22] !== want.response)
                        report_mismatch($sformatf("response %h, expected %h at (%0d,%0d)",
                                                  m_axis_tdata[69:22], want.response,
                                                  want.col, want.row));
                end
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [46:0] value);
    begin
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    end
    endtask

    // Waits until every pixel is sent and every corner has come, then lets the pipe drain.
    task automatic wait_drained();
    begin
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || corner_q.size() != 0);
        repeat (30) @(posedge clk);
    end
    endtask

    // Queues one frame. A frame of blocks gives real corners; the broken kind adds
    // stray frame starts in the middle of the frame.
    task automatic push_frame(input int w, input int h, input int pattern);
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          lo;
        int          hi;
        pixel_item_t item;
        begin
            x0 = $urandom_range(0, w - 1);
            x1 = $urandom_range(x0, w);
            y0 = $urandom_range(0, h - 1);
            y1 = $urandom_range(y0, h);
            lo = $urandom_range(0, 80);
            hi = $urandom_range(150, 255);
            for (int y = 0; y < h; y++)
            begin
                for (int x = 0; x < w; x++)
                begin
                    item.frame_start = (x == 0 && y == 0);
                    case (pattern)
                        PAT_CHECKER: item.pixel = ((x + y) % 2 != 0) ? 8'd255 : 8'd0;
                        PAT_BLOCKS:
                        begin
                            item.pixel = (x >= x0 && x < x1 && y >= y0 && y < y1) ?
                                         8'(hi) : 8'(lo);
                            if ($urandom_range(0, 9) == 0)
                                item.pixel = item.pixel ^ 8'($urandom_range(0, 15));
                        end
                        PAT_BROKEN:
                        begin
                            item.pixel = 8'($urandom_range(0, 255));
                            if ($urandom_range(0, 59) == 0)
                                item.frame_start = 1'b1;
                        end
                        default: item.pixel = 8'($urandom_range(0, 255));
                    endcase
                    pixel_q.insert(pixel_q.size(), item);
                end
            end
        end
    endtask

    // Programs all registers, streams some frames and waits until the block is idle.
    task automatic run_phase(input int w_raw, input int h_raw, input int m_raw,
                             input int k, input longint unsigned thresh,
                             input int frames, input int pattern);
        int w;
        int h;
        begin
            write_reg(REG_IMAGE_WIDTH, 47'(w_raw));
            write_reg(REG_IMAGE_HEIGHT, 47'(h_raw));
            write_reg(REG_BORDER_MARGIN, 47'(m_raw));
            write_reg(REG_HARRIS_K, 47'(k));
            write_reg(REG_CORNER_THRESHOLD, 47'(thresh));
            w = (w_raw < 3) ? 3 : (w_raw > MAX_W ? MAX_W : w_raw);
            h = (h_raw < 3) ? 3 : h_raw;
            for (int f = 0; f < frames; f++)
                push_frame(w, h, (pattern == PAT_ANY) ? $urandom_range(0, 9) % 4 : pattern);
            wait_drained();
        end
    endtask

    initial
    begin
        longint unsigned thresh;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        hold_req       = 1'b0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        width_reg      = 640;
        height_reg     = 480;
        margin_reg     = 10;
        k_reg          = 13107;
        thresh_reg     = 64'd10000000;
        col_pos        = 0;
        row_pos        = 0;
        for (int i = 0; i < MAX_W; i++)
        begin
            pix_row1[i] = '0;
            pix_row2[i] = '0;
            gx_row1[i]  = '0;
            gy_row1[i]  = '0;
            gx_row2[i]  = '0;
            gy_row2[i]  = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                pix_win[i][j]  = 0;
                grad_win[i][j] = 0;
            end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: sizes and margin below their floor, full-scale checker pixels,
        // then one small frame with a single bright block and a zero threshold.
        run_phase(0, 1, 0, 0, 0, 1, PAT_CHECKER);
        run_phase(5, 5, 1, 65535, 0, 1, PAT_BLOCKS);

        // Random part over many small settings. The long receiver hold-off falls on a
        // phase with a zero threshold while the sender keeps offering pixels.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: thresh = 0;
                1: thresh = 64'($urandom_range(0, 100000));
                2: thresh = 64'd10000000;
                default: thresh = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF;
            endcase
            if (ph == 4)
            begin
                @(posedge clk);
                hold_req <= ~hold_req;
            end
            run_phase($urandom_range(5, 11), $urandom_range(5, 9), $urandom_range(0, 4),
                      (ph == 5) ? 65535 : $urandom_range(0, 65535), thresh,
                      $urandom_range(1, 2), PAT_ANY);
        end

        // Extremes: largest margin, full threshold bits and a threshold over all bits.
        run_phase(12, 10, 63, $urandom_range(0, 65535), 0, 1, PAT_BLOCKS);
        run_phase(12, 10, 2, 0, 64'h0000_7FFF_FFFF_FFFF, 1, PAT_CHECKER);
        run_phase(12, 10, 2, $urandom_range(0, 65535),
                  {$urandom, $urandom} & 64'h0000_7FFF_FFFF_FFFF, 1, PAT_NOISE);

        if (corner_q.size() != 0)
            report_mismatch($sformatf("%0d corners never arrived", corner_q.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
